@@ hdl/fic_pkg.sv @@
`default_nettype none

package fic_pkg;

   localparam int POS_W = 16;
   localparam int WORD_W = 32;
   localparam int CSR_INDEX_W = 8;
   localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [WORD_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_EXPECTED_MAGIC   = 8'd0,
      REG_FRAME_LENGTH     = 8'd1,
      REG_SEQUENCE_MODULUS = 8'd2,
      REG_CRC_CHECK_ENABLE = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic [WORD_W-1:0] expected_magic;
      logic [POS_W-1:0]  frame_length;
      logic [WORD_W-1:0] sequence_modulus;
      logic              crc_check_enable;
   } cfg_type;

   typedef struct packed {
      logic              len_ok;
      logic [WORD_W-1:0] magic;
      logic [WORD_W-1:0] seq_num;
      logic              crc_match;
   } frame_sum_type;

   function automatic logic [WORD_W-1:0] crc32_byte(input logic [WORD_W-1:0] acc,
                                                    input logic [7:0] b);
      logic [WORD_W-1:0] c;
      c = acc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ hdl/fic_rem_unit.sv @@
`default_nettype none

module fic_rem_unit
   import fic_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [WORD_W:0]   dividend,
   input  wire logic [WORD_W-1:0] divisor,
   output logic                   busy,
   output logic                   done,
   output logic [WORD_W-1:0]      remainder
);

   localparam int STEPS = WORD_W + 1;
   localparam int CNT_W = $clog2(STEPS);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WORD_W:0]   rem_ff, rem_in;
   logic [WORD_W:0]   dividend_ff, dividend_in;
   logic [WORD_W-1:0] divisor_ff, divisor_in;
   logic [WORD_W:0]   trial;

   always_comb begin
      trial = {rem_ff[WORD_W-1:0], dividend_ff[WORD_W]};
      busy_in = busy_ff;
      done_in = 1'b0;
      count_in = count_ff;
      rem_in = rem_ff;
      dividend_in = dividend_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in = 1'b1;
         count_in = CNT_W'(STEPS - 1);
         rem_in = '0;
         dividend_in = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in = (trial >= {1'b0, divisor_ff}) ? trial - {1'b0, divisor_ff} : trial;
         dividend_in = {dividend_ff[WORD_W-1:0], 1'b0};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      dividend_ff <= dividend_in;
      divisor_ff <= divisor_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign remainder = rem_ff[WORD_W-1:0];

endmodule

`default_nettype wire

@@ hdl/fic_frame_acc.sv @@
`default_nettype none

module fic_frame_acc
   import fic_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 65535
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic             req_end_of_frame,
   output logic                  req_stall,
   input  wire logic [POS_W-1:0] frame_length,
   input  wire logic             verdict_ready,
   output logic                  frame_done,
   output frame_sum_type         frame_sum
);

   localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);

   logic              hold_valid_ff, hold_valid_in;
   logic [7:0]        hold_byte_ff;
   logic              hold_eof_ff;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [WORD_W-1:0] crc_ff, crc_in;
   logic [WORD_W-1:0] tail_ff, tail_in;
   logic [WORD_W-1:0] magic_ff, magic_in;
   logic [WORD_W-1:0] seq_ff, seq_in;
   logic              ovf_ff, ovf_in;
   logic              advance;
   logic              accept;

   assign advance = hold_valid_ff && (!hold_eof_ff || verdict_ready);
   assign req_stall = hold_valid_ff && !advance;
   assign accept = req_valid && !req_stall;
   assign frame_done = advance && hold_eof_ff;

   always_comb begin
      pos_in = pos_ff;
      crc_in = crc_ff;
      tail_in = tail_ff;
      magic_in = magic_ff;
      seq_in = seq_ff;
      ovf_in = ovf_ff;
      if (pos_ff < POS_W'(4)) begin
         magic_in[pos_ff[1:0]*8 +: 8] = hold_byte_ff;
      end else if (pos_ff < POS_W'(8)) begin
         seq_in[pos_ff[1:0]*8 +: 8] = hold_byte_ff;
      end
      if (pos_ff >= POS_W'(4)) begin
         crc_in = crc32_byte(crc_ff, tail_ff[7:0]);
      end
      tail_in = {hold_byte_ff, tail_ff[WORD_W-1:8]};
      if (pos_ff >= MAX_POS) begin
         ovf_in = 1'b1;
      end else begin
         pos_in = pos_ff + 1'b1;
      end
      frame_sum.len_ok = !ovf_in && (pos_in == frame_length);
      frame_sum.magic = magic_in;
      frame_sum.seq_num = seq_in;
      frame_sum.crc_match = ((crc_in ^ CRC_INIT) == tail_in);
      hold_valid_in = accept || (hold_valid_ff && !advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         pos_ff <= '0;
         crc_ff <= CRC_INIT;
         tail_ff <= '0;
         magic_ff <= '0;
         seq_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         if (advance) begin
            if (hold_eof_ff) begin
               pos_ff <= '0;
               crc_ff <= CRC_INIT;
               tail_ff <= '0;
               magic_ff <= '0;
               seq_ff <= '0;
               ovf_ff <= 1'b0;
            end else begin
               pos_ff <= pos_in;
               crc_ff <= crc_in;
               tail_ff <= tail_in;
               magic_ff <= magic_in;
               seq_ff <= seq_in;
               ovf_ff <= ovf_in;
            end
         end
      end
      if (accept) begin
         hold_byte_ff <= req_data_byte;
         hold_eof_ff <= req_end_of_frame;
      end
   end

endmodule

`default_nettype wire

@@ hdl/fic_verdict.sv @@
`default_nettype none

module fic_verdict
   import fic_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              modulus_write,
   input  wire logic [WORD_W-1:0] modulus_data,
   input  wire logic              frame_done,
   input  wire frame_sum_type     frame_sum,
   output logic                   verdict_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_frame_ok,
   output logic                   rsp_length_bad,
   output logic                   rsp_magic_bad,
   output logic                   rsp_sequence_bad,
   output logic                   rsp_crc_bad,
   output logic [WORD_W-1:0]      rsp_frame_sequence,
   output logic [WORD_W-1:0]      rsp_total_received,
   output logic [WORD_W-1:0]      rsp_total_valid,
   output logic [WORD_W-1:0]      rsp_total_magic_errors,
   output logic [WORD_W-1:0]      rsp_total_sequence_errors,
   output logic [WORD_W-1:0]      rsp_total_crc_errors
);

   logic              rsp_valid_ff, rsp_valid_in;
   logic              ok_ff, len_bad_ff, magic_bad_ff, seq_bad_ff, crc_bad_ff;
   logic [WORD_W-1:0] seq_out_ff;
   logic [WORD_W-1:0] prev_ff, expect_ff;
   logic              seen_ff;
   logic [WORD_W-1:0] rx_cnt_ff, valid_cnt_ff, magic_cnt_ff, seq_cnt_ff, crc_cnt_ff;
   logic [WORD_W-1:0] rx_cnt_in, valid_cnt_in, magic_cnt_in, seq_cnt_in, crc_cnt_in;
   logic              m_bad, range_bad, pre_ok, cont_bad, s_bad, c_bad, ok;
   logic [WORD_W:0]   seq_next;
   logic [WORD_W-1:0] expect_next;
   logic [WORD_W-1:0] expect_cur;
   logic              rem_busy, rem_done;
   logic [WORD_W-1:0] rem_value;

   fic_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (modulus_write),
      .dividend  ({1'b0, prev_ff} + 1'b1),
      .divisor   (modulus_data),
      .busy      (rem_busy),
      .done      (rem_done),
      .remainder (rem_value)
   );

   assign verdict_ready = (!rsp_valid_ff || !rsp_stall) && !rem_busy && !modulus_write;

   always_comb begin
      expect_cur = rem_done ? rem_value : expect_ff;
      m_bad = frame_sum.len_ok && (frame_sum.magic != cfg.expected_magic);
      range_bad = frame_sum.len_ok && (frame_sum.seq_num >= cfg.sequence_modulus);
      pre_ok = frame_sum.len_ok && !m_bad && !range_bad;
      cont_bad = pre_ok && seen_ff && (cfg.sequence_modulus != '0)
                 && (frame_sum.seq_num != expect_cur);
      s_bad = range_bad || cont_bad;
      c_bad = frame_sum.len_ok && cfg.crc_check_enable && !frame_sum.crc_match;
      ok = pre_ok && !cont_bad && !c_bad;
      seq_next = {1'b0, frame_sum.seq_num} + 1'b1;
      expect_next = (seq_next == {1'b0, cfg.sequence_modulus}) ? '0 : seq_next[WORD_W-1:0];
      rx_cnt_in = rx_cnt_ff + 1'b1;
      valid_cnt_in = valid_cnt_ff + WORD_W'(ok);
      magic_cnt_in = magic_cnt_ff + WORD_W'(m_bad);
      seq_cnt_in = seq_cnt_ff + WORD_W'(s_bad);
      crc_cnt_in = crc_cnt_ff + WORD_W'(c_bad);
      rsp_valid_in = frame_done || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         prev_ff <= '0;
         expect_ff <= WORD_W'(1);
         seen_ff <= 1'b0;
         rx_cnt_ff <= '0;
         valid_cnt_ff <= '0;
         magic_cnt_ff <= '0;
         seq_cnt_ff <= '0;
         crc_cnt_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (rem_done) begin
            expect_ff <= rem_value;
         end
         if (frame_done) begin
            rx_cnt_ff <= rx_cnt_in;
            valid_cnt_ff <= valid_cnt_in;
            magic_cnt_ff <= magic_cnt_in;
            seq_cnt_ff <= seq_cnt_in;
            crc_cnt_ff <= crc_cnt_in;
            if (ok) begin
               prev_ff <= frame_sum.seq_num;
               expect_ff <= expect_next;
               seen_ff <= 1'b1;
            end
         end
      end
      if (frame_done) begin
         ok_ff <= ok;
         len_bad_ff <= !frame_sum.len_ok;
         magic_bad_ff <= m_bad;
         seq_bad_ff <= s_bad;
         crc_bad_ff <= c_bad;
         seq_out_ff <= frame_sum.seq_num;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_frame_ok = ok_ff;
   assign rsp_length_bad = len_bad_ff;
   assign rsp_magic_bad = magic_bad_ff;
   assign rsp_sequence_bad = seq_bad_ff;
   assign rsp_crc_bad = crc_bad_ff;
   assign rsp_frame_sequence = seq_out_ff;
   assign rsp_total_received = rx_cnt_ff;
   assign rsp_total_valid = valid_cnt_ff;
   assign rsp_total_magic_errors = magic_cnt_ff;
   assign rsp_total_sequence_errors = seq_cnt_ff;
   assign rsp_total_crc_errors = crc_cnt_ff;

endmodule

`default_nettype wire

@@ hdl/frame_integrity_checker.sv @@
// A byte is registered in a holding register on acceptance; when the last byte of a frame leaves
// it, the verdict is loaded into the result register that drives rsp_valid. The checker takes one
// byte per cycle while req_stall is low, with a byte-wide CRC32 update between the two registers.
// A write to the sequence modulus recomputes the expected sequence in a bit-serial remainder unit;
// a frame end waits for it. Reset is synchronous and active high; it restores the configuration,
// counters and per-frame state to their defaults and empties both registers.
`default_nettype none

module frame_integrity_checker
   import fic_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 65535
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_data_byte,
   input  wire logic                   req_end_of_frame,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_frame_ok,
   output logic                        rsp_length_bad,
   output logic                        rsp_magic_bad,
   output logic                        rsp_sequence_bad,
   output logic                        rsp_crc_bad,
   output logic [WORD_W-1:0]           rsp_frame_sequence,
   output logic [WORD_W-1:0]           rsp_total_received,
   output logic [WORD_W-1:0]           rsp_total_valid,
   output logic [WORD_W-1:0]           rsp_total_magic_errors,
   output logic [WORD_W-1:0]           rsp_total_sequence_errors,
   output logic [WORD_W-1:0]           rsp_total_crc_errors,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]      csr_write_data
);

   cfg_type       cfg_ff;
   frame_sum_type frame_sum;
   logic          frame_done;
   logic          verdict_ready;
   logic          modulus_write;

   assign modulus_write = csr_write_enable && (csr_index == REG_SEQUENCE_MODULUS);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_magic <= '0;
         cfg_ff.frame_length <= POS_W'(5120);
         cfg_ff.sequence_modulus <= WORD_W'(256);
         cfg_ff.crc_check_enable <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_EXPECTED_MAGIC: begin
               cfg_ff.expected_magic <= csr_write_data;
            end
            REG_FRAME_LENGTH: begin
               cfg_ff.frame_length <= csr_write_data[POS_W-1:0];
            end
            REG_SEQUENCE_MODULUS: begin
               cfg_ff.sequence_modulus <= csr_write_data;
            end
            REG_CRC_CHECK_ENABLE: begin
               cfg_ff.crc_check_enable <= csr_write_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   fic_frame_acc #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_frame_acc (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_data_byte    (req_data_byte),
      .req_end_of_frame (req_end_of_frame),
      .req_stall        (req_stall),
      .frame_length     (cfg_ff.frame_length),
      .verdict_ready    (verdict_ready),
      .frame_done       (frame_done),
      .frame_sum        (frame_sum)
   );

   fic_verdict u_verdict (
      .clock                     (clock),
      .reset                     (reset),
      .cfg                       (cfg_ff),
      .modulus_write             (modulus_write),
      .modulus_data              (csr_write_data),
      .frame_done                (frame_done),
      .frame_sum                 (frame_sum),
      .verdict_ready             (verdict_ready),
      .rsp_valid                 (rsp_valid),
      .rsp_stall                 (rsp_stall),
      .rsp_frame_ok              (rsp_frame_ok),
      .rsp_length_bad            (rsp_length_bad),
      .rsp_magic_bad             (rsp_magic_bad),
      .rsp_sequence_bad          (rsp_sequence_bad),
      .rsp_crc_bad               (rsp_crc_bad),
      .rsp_frame_sequence        (rsp_frame_sequence),
      .rsp_total_received        (rsp_total_received),
      .rsp_total_valid           (rsp_total_valid),
      .rsp_total_magic_errors    (rsp_total_magic_errors),
      .rsp_total_sequence_errors (rsp_total_sequence_errors),
      .rsp_total_crc_errors      (rsp_total_crc_errors)
   );

endmodule

`default_nettype wire
